@@ src/kdlp_pkg.sv @@
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce / long-press block.
// ----------------------------------------------------------------------------
package kdlp_pkg;

   localparam int KEY_W      = 8;
   localparam int HOLD_W     = 21;
   localparam int REL_W      = 8;
   localparam int LONG_W     = 20;
   localparam int SHORT_W    = 8;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [KEY_W-1:0]  ALL_OFF   = 8'hFF;
   localparam logic [KEY_W-1:0]  LONG_FLAG = 8'h80;
   localparam logic [HOLD_W-1:0] HOLD_MAX  = 21'h1FFFFF;
   localparam logic [REL_W-1:0]  REL_MAX   = 8'hFF;

   localparam logic [LONG_W-1:0]  STARTUP_HOLD_RST = 20'd10000;
   localparam logic [SHORT_W-1:0] DEBOUNCE_RST     = 8'd1;
   localparam logic [LONG_W-1:0]  LONG_PRESS_RST   = 20'd900000;
   localparam logic [SHORT_W-1:0] RELEASE_RST      = 8'd1;

   // register map
   localparam logic [CSR_IDX_W-1:0] REG_STARTUP_HOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE      = 3'd3;

   typedef struct packed {
      logic [LONG_W-1:0]  startup_hold_ticks;
      logic [SHORT_W-1:0] debounce_ticks;
      logic [LONG_W-1:0]  long_press_ticks;
      logic [SHORT_W-1:0] release_ticks;
   } cfg_type;

endpackage

@@ src/kdlp_csr.sv @@
// ----------------------------------------------------------------------------
// kdlp_csr
// Configuration register file; writes to unmapped indexes are dropped.
// ----------------------------------------------------------------------------
module kdlp_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          wr_en,
   input  logic [kdlp_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [kdlp_pkg::CSR_DATA_W-1:0] wr_data,
   output kdlp_pkg::cfg_type             cfg
);
   import kdlp_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            REG_STARTUP_HOLD: cfg_in.startup_hold_ticks = wr_data[LONG_W-1:0];
            REG_DEBOUNCE:     cfg_in.debounce_ticks     = wr_data[SHORT_W-1:0];
            REG_LONG_PRESS:   cfg_in.long_press_ticks   = wr_data[LONG_W-1:0];
            REG_RELEASE:      cfg_in.release_ticks      = wr_data[SHORT_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.startup_hold_ticks <= STARTUP_HOLD_RST;
         cfg_ff.debounce_ticks     <= DEBOUNCE_RST;
         cfg_ff.long_press_ticks   <= LONG_PRESS_RST;
         cfg_ff.release_ticks      <= RELEASE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ src/kdlp_encode.sv @@
// ----------------------------------------------------------------------------
// kdlp_encode
// Fixed-priority key encoder: lowest pressed key wins, active-low pattern.
// ----------------------------------------------------------------------------
module kdlp_encode #(
   parameter int KEY_COUNT = 8
) (
   input  logic [kdlp_pkg::KEY_W-1:0] key_levels,
   output logic [kdlp_pkg::KEY_W-1:0] pattern
);
   import kdlp_pkg::*;

   logic [KEY_W-1:0] onehot;

   // scan from the top so the lowest set bit is the last one kept
   always_comb begin
      onehot = '0;
      for (int i = KEY_COUNT - 1; i >= 0; i--) begin
         if (key_levels[i]) begin
            onehot    = '0;
            onehot[i] = 1'b1;
         end
      end
   end

   assign pattern = ALL_OFF & ~onehot;

endmodule

@@ src/kdlp_fsm.sv @@
// ----------------------------------------------------------------------------
// kdlp_fsm
// Debounce / long-press phase machine; one pattern per step.
// ----------------------------------------------------------------------------
module kdlp_fsm (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [kdlp_pkg::KEY_W-1:0] pattern,
   input  kdlp_pkg::cfg_type          cfg,
   output logic [kdlp_pkg::KEY_W-1:0] key_event
);
   import kdlp_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_CONFIRM = 3'd1,
      PH_HELD    = 3'd2,
      PH_REPORT  = 3'd3,
      PH_WAIT    = 3'd4
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [KEY_W-1:0]  held_pattern_ff, held_pattern_in;
   logic [HOLD_W-1:0] hold_count_ff, hold_count_in;
   logic [REL_W-1:0]  release_count_ff, release_count_in;
   logic [KEY_W-1:0]  pending_code_ff, pending_code_in;
   logic              startup_pending_ff, startup_pending_in;

   logic [HOLD_W-1:0] hold_one;
   logic [HOLD_W-1:0] hold_two;
   logic [REL_W-1:0]  rel_one;

   assign hold_one = (hold_count_ff == HOLD_MAX) ? HOLD_MAX : hold_count_ff + 21'd1;
   assign hold_two = (hold_one == HOLD_MAX) ? HOLD_MAX : hold_one + 21'd1;
   assign rel_one  = (release_count_ff == REL_MAX) ? REL_MAX : release_count_ff + 8'd1;

   always_comb begin
      phase_in           = phase_ff;
      held_pattern_in    = held_pattern_ff;
      hold_count_in      = hold_count_ff;
      release_count_in   = release_count_ff;
      pending_code_in    = pending_code_ff;
      startup_pending_in = startup_pending_ff;
      key_event          = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (pattern != ALL_OFF) begin
               held_pattern_in  = pattern;
               hold_count_in    = '0;
               release_count_in = '0;
               phase_in         = PH_CONFIRM;
            end
         end
         PH_CONFIRM: begin
            if (pattern == held_pattern_ff) begin
               if (startup_pending_ff &&
                   hold_one > {1'b0, cfg.startup_hold_ticks}) begin
                  startup_pending_in = 1'b0;
                  pending_code_in    = held_pattern_ff ^ ALL_OFF;
                  hold_count_in      = '0;
                  phase_in           = PH_HELD;
               end else if (!startup_pending_ff &&
                            hold_two > {13'd0, cfg.debounce_ticks}) begin
                  pending_code_in = held_pattern_ff ^ ALL_OFF;
                  hold_count_in   = '0;
                  phase_in        = PH_HELD;
               end else begin
                  // count advances twice per tick while unconfirmed
                  hold_count_in = hold_two;
               end
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_HELD: begin
            if (pattern == held_pattern_ff) begin
               if (hold_one > {1'b0, cfg.long_press_ticks}) begin
                  pending_code_in = pending_code_ff | LONG_FLAG;
                  hold_count_in   = '0;
                  phase_in        = PH_REPORT;
               end else begin
                  hold_count_in = hold_one;
               end
            end else if (pattern == ALL_OFF) begin
               release_count_in = rel_one;
               pending_code_in  = held_pattern_ff ^ ALL_OFF;
               phase_in         = PH_REPORT;
            end
         end
         PH_REPORT: begin
            key_event = pending_code_ff;
            phase_in  = PH_WAIT;
         end
         PH_WAIT: begin
            if (pattern == ALL_OFF) begin
               release_count_in = rel_one;
               if (rel_one > cfg.release_ticks) begin
                  phase_in = PH_IDLE;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= PH_IDLE;
         held_pattern_ff    <= ALL_OFF;
         hold_count_ff      <= '0;
         release_count_ff   <= '0;
         pending_code_ff    <= '0;
         startup_pending_ff <= 1'b1;
      end else if (step) begin
         phase_ff           <= phase_in;
         held_pattern_ff    <= held_pattern_in;
         hold_count_ff      <= hold_count_in;
         release_count_ff   <= release_count_in;
         pending_code_ff    <= pending_code_in;
         startup_pending_ff <= startup_pending_in;
      end
   end

   // a report always lasts one step and leads to the release wait
   a_report_once: assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_REPORT |=> phase_ff == PH_WAIT)
      else $error("report phase did not move to wait-release");

   // the startup hold applies only once after reset
   a_startup_sticky: assert property (@(posedge clock) disable iff (reset)
      !startup_pending_ff |=> !startup_pending_ff)
      else $error("startup flag set again");

   // key code part of the pending code is at most one key
   a_pending_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0(pending_code_ff[KEY_W-2:0]))
      else $error("pending code holds more than one key");

   // no state moves without an item
   a_hold_without_step: assert property (@(posedge clock) disable iff (reset)
      !$past(step) && !$past(reset) |-> $stable(phase_ff) && $stable(hold_count_ff))
      else $error("state changed with no transaction");

endmodule

@@ src/key_debounce_long_press.sv @@
// ----------------------------------------------------------------------------
// key_debounce_long_press
// Debounces eight key levels per tick and reports short and long presses.
// ----------------------------------------------------------------------------
//  channel  ports                                    direction
//  req      req_valid, req_stall, req_key_levels     in  (one scan tick)
//  rsp      rsp_valid, rsp_stall, rsp_key_event      out (one event per tick)
//  csr      csr_valid, csr_ready, csr_index, csr_data in (register write)
//
//  One transaction per cycle unless the result stalls; a request goes into the
//  input register, then the phase machine writes the result register.
//  Reset is synchronous; the phase machine, counters, config registers and
//  valid flags go to their defaults, and csr_ready stays high.
//  A stalled result holds the pipeline; req_stall rises only when the input
//  register is full and cannot move into the result register.
// ----------------------------------------------------------------------------
module key_debounce_long_press #(
   parameter int KEY_COUNT = 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [kdlp_pkg::KEY_W-1:0]      req_key_levels,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kdlp_pkg::KEY_W-1:0]      rsp_key_event,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [kdlp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [kdlp_pkg::CSR_DATA_W-1:0] csr_data
);
   import kdlp_pkg::*;

   logic             in_valid_ff;
   logic [KEY_W-1:0] in_levels_ff;
   logic             out_valid_ff;
   logic [KEY_W-1:0] out_event_ff;

   logic             advance;
   logic             step;
   logic [KEY_W-1:0] pattern;
   logic [KEY_W-1:0] event_in;
   cfg_type          cfg;

   assign advance   = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;
   assign csr_ready = 1'b1;

   kdlp_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid && csr_ready),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   kdlp_encode #(
      .KEY_COUNT (KEY_COUNT)
   ) u_encode (
      .key_levels (in_levels_ff),
      .pattern    (pattern)
   );

   kdlp_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .pattern   (pattern),
      .cfg       (cfg),
      .key_event (event_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_levels_ff <= req_key_levels;
      end
      if (step) begin
         out_event_ff <= event_in;
      end
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_key_event = out_event_ff;

endmodule
